@@ rtl/core/fqst_pkg.sv @@
package fqst_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned OpWidth      = 2;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned CountWidth   = 5;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [OpWidth-1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_DEQUEUE  = 2'd1,
    OP_QUERY    = 2'd2,
    OP_TRUNCATE = 2'd3
  } fqst_op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } fqst_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } fqst_state_e;

endpackage

@@ rtl/core/fqst_if.sv @@
interface fqst_in_if;
  import fqst_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OpWidth-1:0]          op;
  logic signed [DataWidth-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface fqst_out_if;
  import fqst_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [StatusWidth-1:0]      status;
  logic signed [DataWidth-1:0] data;
  logic                        found;
  logic [CountWidth-1:0]       count;

  modport source (output valid, output status, output data, output found, output count,
                  input ready);
  modport sink   (input valid, input status, input data, input found, input count,
                  output ready);
endinterface

@@ rtl/core/fqst_ram.sv @@
module fqst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/fifo_queue_with_search_truncate_core.sv @@
// Sequence: an enqueue writes its slot as it is taken and goes to the done state; a dequeue
// reads the head entry in the read state first; query and truncate go through the scan state,
// which reads one ring entry per cycle from head to tail; a match ends the scan early.
// Throughput: one request at a time; the next one is taken as soon as the sequencer
// is idle, even while the previous result still waits in the output register.
// Reset: asynchronous, active low; the queue comes up empty, slot contents are not cleared.
module fifo_queue_with_search_truncate_core #(
  parameter int unsigned DEPTH = fqst_pkg::DefaultDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  fqst_in_if.sink    in_i,
  fqst_out_if.source out_o
);
  import fqst_pkg::*;

  // Ring index width and the width of a count that can hold DEPTH itself.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // Position in the ring at a given offset from the head. The offset is always
  // below DEPTH, so one compare and subtract wraps the sum.
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  fqst_state_e state_q, state_d;

  // Queue bookkeeping.
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Request being worked on.
  fqst_op_e       op_q, op_d;
  logic [DataWidth-1:0] value_q, value_d;

  // Scan pointers: idx is the next offset to read, pend marks a read whose data
  // arrives this cycle for offset pend_off.
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] pend_off_q, pend_off_d;

  // Result waiting for the output register.
  fqst_status_e         res_status_q, res_status_d;
  logic [DataWidth-1:0] res_data_q, res_data_d;
  logic                 res_found_q, res_found_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  fqst_status_e           out_status_q, out_status_d;
  logic [DataWidth-1:0]   out_data_q, out_data_d;
  logic                   out_found_q, out_found_d;
  logic [CountWidth-1:0]  out_count_q, out_count_d;

  // RAM port.
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DataWidth-1:0] ram_rdata;

  logic in_xfer, out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  fqst_ram #(
    .Width (DataWidth),
    .Depth (DEPTH),
    .AddrW (AW)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_d),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    value_d      = value_q;
    idx_d        = idx_q;
    pend_d       = 1'b0;
    pend_off_d   = pend_off_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = ring_pos(head_q, cnt_q[AW-1:0]);
    ram_raddr    = ring_pos(head_q, idx_q[AW-1:0]);

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d         = fqst_op_e'(in_i.op);
          value_d      = in_i.value;
          res_status_d = ST_OK;
          res_data_d   = '0;
          res_found_d  = 1'b0;
          idx_d        = '0;
          unique case (fqst_op_e'(in_i.op))
            OP_ENQUEUE: begin
              // The slot is written right away; the count follows in the same edge.
              if (cnt_q >= DepthC) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
              state_d = S_DONE;
            end
            OP_DEQUEUE: begin
              if (cnt_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                state_d   = S_READ;
              end
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end

      S_READ: begin
        // The head entry arrives from the RAM in this cycle.
        res_data_d = ram_rdata;
        head_d     = ring_pos(head_q, AW'(1));
        cnt_d      = cnt_q - CW'(1);
        state_d    = S_DONE;
      end

      S_SCAN: begin
        // Issue one read per cycle and compare the data of the previous one, so
        // the shared comparator sees one entry per cycle in head-to-tail order.
        if (pend_q && (ram_rdata == value_q)) begin
          res_found_d = 1'b1;
          if (op_q == OP_TRUNCATE) begin
            cnt_d = pend_off_q + CW'(1);
          end
          state_d = S_DONE;
        end else if (idx_q < cnt_q) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_off_d = idx_q;
          idx_d      = idx_q + CW'(1);
        end else if (!pend_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          out_found_d  = res_found_q;
          out_count_d  = CountWidth'(cnt_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    value_q      <= value_d;
    idx_q        <= idx_d;
    pend_off_q   <= pend_off_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.data   = out_data_q;
  assign out_o.found  = out_found_q;
  assign out_o.count  = out_count_q;

  // The queue never holds more than DEPTH items.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("item count exceeds ring depth");

  // An accepted request always leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after an input transfer");

  // A pending compare always belongs to the offset just before the read pointer.
  a_pend_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN) && (idx_q == pend_off_q + CW'(1)))
    else $error("scan compare out of step with read pointer");

  // A result is loaded into the output register only from the done state.
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside the done state");

endmodule

@@ bench/fqst_queue_checker.sv @@
module fqst_queue_checker
  import fqst_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fqst_in_if          in_i,
  fqst_out_if         out_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [DataWidth-1:0]   data;
    logic                   found;
    logic [CountWidth-1:0]  count;
  } queue_result_t;

  // Shadow copy of the queue, kept in step with every accepted request.
  logic [DataWidth-1:0] ring [DEPTH];
  int unsigned          head_pos;
  int unsigned          held;
  queue_result_t        awaited_results[$];
  queue_result_t        oldest;
  int unsigned          errors;

  function automatic queue_result_t apply_request(fqst_op_e op, logic [DataWidth-1:0] v);
    queue_result_t r;
    int unsigned   hit;
    r = '0;
    r.status = ST_OK;
    hit = held;
    for (int unsigned i = 0; i < held; i++) begin
      if (ring[(head_pos + i) % DEPTH] == v) begin
        hit = i;
        break;
      end
    end
    case (op)
      OP_ENQUEUE: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[(head_pos + held) % DEPTH] = v;
          held++;
        end
      end
      OP_DEQUEUE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = ring[head_pos];
          head_pos = (head_pos + 1) % DEPTH;
          held--;
        end
      end
      OP_QUERY: begin
        r.found = (hit < held);
      end
      default: begin
        if (hit < held) begin
          r.found = 1'b1;
          held = hit + 1;
        end
      end
    endcase
    r.count = CountWidth'(held);
    return r;
  endfunction

  function automatic void check_field(string name, logic [DataWidth-1:0] want,
                                      logic [DataWidth-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_pos = 0;
      held = 0;
      errors = 0;
      awaited_results.delete();
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with none expected, got status %0d data %h found %0d count %0d",
                   $time, out_i.status, out_i.data, out_i.found, out_i.count);
          errors++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", DataWidth'(oldest.status), DataWidth'(out_i.status));
          check_field("data", oldest.data, out_i.data);
          check_field("found", DataWidth'(oldest.found), DataWidth'(out_i.found));
          check_field("count", DataWidth'(oldest.count), DataWidth'(out_i.count));
        end
      end
      if (in_i.valid && in_i.ready) begin
        awaited_results.push_back(apply_request(fqst_op_e'(in_i.op), in_i.value));
      end
      mismatches_o <= errors;
      pending_o <= awaited_results.size();
    end
  end

endmodule

@@ bench/fifo_queue_with_search_truncate_core_test.sv @@
module fifo_queue_with_search_truncate_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fqst_pkg::*;

  localparam int unsigned ClkPeriodNs   = 12;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned RandomItems   = 600;
  // The longest correct pause without any transfer is a full scan plus both
  // idle draws, far below this limit; the drain at the end stays well below it too.
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = DefaultDepth + 8;

  logic clk = 1'b0;
  logic rst_n;

  // When set, neither side inserts idle cycles, so back-to-back transfers occur.
  logic no_idle;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles;
  int unsigned ready_hold;
  int unsigned stall;

  // Small set of values reused by enqueues and searches so that queries and
  // truncates hit stored items often, duplicates included.
  logic [DataWidth-1:0] value_pool [8];

  fqst_in_if  in_ch ();
  fqst_out_if out_ch ();

  fifo_queue_with_search_truncate_core #(
    .DEPTH(DefaultDepth)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  fqst_queue_checker #(
    .DEPTH(DefaultDepth)
  ) checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always #(ClkPeriodNs / 2) clk = ~clk;

  // Result side: after each result transfer the sink draws a random stall, unless
  // no_idle is set. The countdown runs regardless of what the block is doing, so ready
  // can be low in the early part of a scan or while a result waits in the output register.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      ready_hold <= stall;
      out_ch.ready <= (stall == 0);
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ch.ready <= (ready_hold == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: a block that stops taking requests or stops producing results
  // ends the run here.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        if (quiet_cycles >= WatchdogLimit) begin
          $display("DONE: errors detected");
          $finish;
        end
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one request and holds it until the block takes it. Valid stays
  // high across back-to-back requests and is lowered only for an idle gap.
  task automatic send_request(fqst_op_e op, logic [DataWidth-1:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Draws a value from the reuse pool with the given chance in percent, and
  // a fully random 32-bit pattern otherwise.
  function automatic logic [DataWidth-1:0] pick_value(int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) begin
      return value_pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  initial begin
    fqst_op_e             op;
    logic [DataWidth-1:0] v;
    int unsigned          roll;
    logic                 fill_phase;

    rst_n        = 1'b0;
    no_idle      = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_ENQUEUE;
    in_ch.value  = '0;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. An empty queue first: dequeue reports empty, and both
    // searches find nothing and leave the queue alone.
    send_request(OP_DEQUEUE, 32'h0000_0000);
    send_request(OP_QUERY, 32'h0000_0000);
    send_request(OP_TRUNCATE, 32'h0000_0000);

    // The extreme patterns of the value field, searched for on the full
    // 32-bit pattern: a neighbor of a stored value must not match.
    send_request(OP_ENQUEUE, 32'h7FFF_FFFF);
    send_request(OP_ENQUEUE, 32'h8000_0000);
    send_request(OP_ENQUEUE, 32'hFFFF_FFFF);
    send_request(OP_ENQUEUE, 32'h0000_0000);
    send_request(OP_QUERY, 32'h8000_0000);
    send_request(OP_QUERY, 32'h7FFF_FFFE);
    // A truncate without a match keeps all four items.
    send_request(OP_TRUNCATE, 32'h1234_5678);

    // Fill to the top, then an enqueue into a full queue is refused.
    for (int i = 0; i < DefaultDepth - 4; i++) begin
      v = $urandom;
      send_request(OP_ENQUEUE, v);
    end
    send_request(OP_ENQUEUE, 32'hA5A5_A5A5);

    // A match on the last slot keeps everything; a match on the head keeps
    // only the head, which the dequeue then takes out.
    send_request(OP_TRUNCATE, v);
    send_request(OP_TRUNCATE, 32'h7FFF_FFFF);
    send_request(OP_DEQUEUE, 32'h0000_0000);

    // Random part. Phases that favor enqueues alternate with phases that favor
    // dequeues so that the count sweeps between empty and full; searches mostly
    // use pooled values so that they find something. Now and then a stretch
    // runs with no idle cycles on either side.
    for (int n = 0; n < RandomItems; n++) begin
      fill_phase = ((n / 48) % 2) == 0;
      no_idle <= ((n / 32) % 5) == 4;
      roll = $urandom_range(0, 99);
      if (fill_phase) begin
        op = (roll < 60) ? OP_ENQUEUE : (roll < 75) ? OP_DEQUEUE :
             (roll < 90) ? OP_QUERY : OP_TRUNCATE;
      end else begin
        op = (roll < 20) ? OP_ENQUEUE : (roll < 60) ? OP_DEQUEUE :
             (roll < 82) ? OP_QUERY : OP_TRUNCATE;
      end
      if (op == OP_ENQUEUE) begin
        v = pick_value(45);
        if ($urandom_range(0, 3) == 0) value_pool[$urandom_range(4, 7)] = v;
      end else begin
        v = pick_value(70);
      end
      send_request(op, v);
    end
    in_ch.valid <= 1'b0;

    // Let the checker see the last request, wait for every result, then give
    // a stray extra result time to show up.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
